/* rtl/bbrf_pkg.sv */
// bbrf_pkg: beat types, action codes and character constants of the brace range finder
// used by every module of the block; depends on nothing
package bbrf_pkg;

  localparam int OUT_LINE_W = 20;
  localparam int EXCESS_W   = 16;

  typedef enum logic [1:0] {
    ACT_CHAR = 2'd0,
    ACT_EOL  = 2'd1,
    ACT_SOF  = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [OUT_LINE_W-1:0] open_line;
    logic [OUT_LINE_W-1:0] close_line;
    logic                  overflowed;
  } out_item_t;

  // stack operation issued by the scanner for one beat
  typedef struct packed {
    logic push;
    logic pop;
    logic ovf;
  } stack_cmd_t;

endpackage

/* rtl/brace_block_range_finder_top.sv */
// brace_block_range_finder_top: pairs curly braces in a character stream by line number
// depends on bbrf_pkg, bbrf_scan, bbrf_stack
//
//   channel | dir | handshake            | beat
//   in_     | in  | in_valid / in_stall   | action, char_code
//   out_    | out | out_valid / out_stall | open_line, close_line, overflowed
//
// one input beat per cycle unless in_stall holds it; a pop reads the stack memory, and
// the next cycle compares the stored line and, if the output is free, loads the result
// register (no result for braces on one line). reset clears flags, counters and stack
// pointer, not memory. in_stall rises only while a pop waits behind a stalled result.
module brace_block_range_finder_top #(
  parameter int STACK_DEPTH = 64,
  parameter int LINE_BITS   = 20
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bbrf_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output bbrf_pkg::out_item_t out_item
);
  import bbrf_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);

  stack_cmd_t           cmd;
  logic [AW-1:0]        addr;
  logic [LINE_BITS-1:0] line;
  logic                 s2_free;
  logic                 accept;

  assign in_stall = !s2_free;
  assign accept   = in_valid && s2_free;

  bbrf_scan #(
    .STACK_DEPTH (STACK_DEPTH),
    .LINE_BITS   (LINE_BITS),
    .AW          (AW)
  ) u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_item),
    .cmd    (cmd),
    .addr   (addr),
    .line   (line)
  );

  bbrf_stack #(
    .STACK_DEPTH (STACK_DEPTH),
    .LINE_BITS   (LINE_BITS),
    .AW          (AW)
  ) u_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .addr      (addr),
    .line      (line),
    .s2_free   (s2_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

/* rtl/bbrf_scan.sv */
// bbrf_scan: lexer flags, line counter and stack pointer; issues push and pop commands
// depends on bbrf_pkg
module bbrf_scan #(
  parameter int STACK_DEPTH = 64,
  parameter int LINE_BITS   = 20,
  parameter int AW          = $clog2(STACK_DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  bbrf_pkg::in_item_t    item,
  output bbrf_pkg::stack_cmd_t  cmd,
  output logic [AW-1:0]         addr,
  output logic [LINE_BITS-1:0]  line
);
  import bbrf_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [LINE_BITS-1:0] line_r, line_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [EXCESS_W-1:0]  excess_r, excess_nxt;
  logic ovf_r, ovf_nxt;
  logic blk_r, blk_nxt;
  logic star_r, star_nxt;
  logic slash_r, slash_nxt;
  logic lit_r, lit_nxt;
  logic single_r, single_nxt;
  logic esc_r, esc_nxt;
  logic lcom_r, lcom_nxt;
  logic push, pop;
  logic [7:0] c;
  logic [7:0] quote;
  logic plain;

  assign c     = item.char_code;
  assign quote = single_r ? CH_SQUOTE : CH_DQUOTE;

  always_comb begin
    line_nxt   = line_r;
    count_nxt  = count_r;
    excess_nxt = excess_r;
    ovf_nxt    = ovf_r;
    blk_nxt    = blk_r;
    star_nxt   = star_r;
    slash_nxt  = slash_r;
    lit_nxt    = lit_r;
    single_nxt = single_r;
    esc_nxt    = esc_r;
    lcom_nxt   = lcom_r;
    push       = 1'b0;
    pop        = 1'b0;
    plain      = 1'b0;
    if (accept) begin
      unique case (action_t'(item.action))
        ACT_CHAR: begin
          priority if (lcom_r) begin
          end else if (blk_r) begin
            if (star_r && c == CH_SLASH) begin
              blk_nxt  = 1'b0;
              star_nxt = 1'b0;
            end else begin
              star_nxt = (c == CH_STAR);
            end
          end else if (lit_r) begin
            priority if (esc_r) esc_nxt = 1'b0;
            else if (c == CH_BSLASH) esc_nxt = 1'b1;
            else if (c == quote) lit_nxt = 1'b0;
            else begin
            end
          end else if (slash_r) begin
            slash_nxt = 1'b0;
            priority if (c == CH_SLASH) lcom_nxt = 1'b1;
            else if (c == CH_STAR) begin
              blk_nxt  = 1'b1;
              star_nxt = 1'b0;
            end else plain = 1'b1;
          end else begin
            plain = 1'b1;
          end
          if (plain) begin
            priority if (c == CH_SLASH) slash_nxt = 1'b1;
            else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
              lit_nxt    = 1'b1;
              single_nxt = (c == CH_SQUOTE);
              esc_nxt    = 1'b0;
            end else if (c == CH_LBRACE) begin
              if (count_r < CW'(STACK_DEPTH)) begin
                push      = 1'b1;
                count_nxt = count_r + 1'b1;
              end else begin
                if (!(&excess_r)) excess_nxt = excess_r + 1'b1;
                ovf_nxt = 1'b1;
              end
            end else if (c == CH_RBRACE) begin
              priority if (excess_r != '0) excess_nxt = excess_r - 1'b1;
              else if (count_r != '0) begin
                pop       = 1'b1;
                count_nxt = count_r - 1'b1;
              end else begin
              end
            end else begin
            end
          end
        end
        ACT_EOL: begin
          lcom_nxt   = 1'b0;
          lit_nxt    = 1'b0;
          single_nxt = 1'b0;
          esc_nxt    = 1'b0;
          slash_nxt  = 1'b0;
          star_nxt   = 1'b0;
          if (!(&line_r)) line_nxt = line_r + 1'b1;
        end
        ACT_SOF: begin
          line_nxt   = '0;
          count_nxt  = '0;
          excess_nxt = '0;
          ovf_nxt    = 1'b0;
          blk_nxt    = 1'b0;
          lcom_nxt   = 1'b0;
          lit_nxt    = 1'b0;
          single_nxt = 1'b0;
          esc_nxt    = 1'b0;
          slash_nxt  = 1'b0;
          star_nxt   = 1'b0;
        end
        ACT_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r   <= '0;
      count_r  <= '0;
      excess_r <= '0;
      ovf_r    <= 1'b0;
      blk_r    <= 1'b0;
      star_r   <= 1'b0;
      slash_r  <= 1'b0;
      lit_r    <= 1'b0;
      single_r <= 1'b0;
      esc_r    <= 1'b0;
      lcom_r   <= 1'b0;
    end else begin
      line_r   <= line_nxt;
      count_r  <= count_nxt;
      excess_r <= excess_nxt;
      ovf_r    <= ovf_nxt;
      blk_r    <= blk_nxt;
      star_r   <= star_nxt;
      slash_r  <= slash_nxt;
      lit_r    <= lit_nxt;
      single_r <= single_nxt;
      esc_r    <= esc_nxt;
      lcom_r   <= lcom_nxt;
    end
  end

  logic [CW-1:0] pop_idx;
  assign pop_idx = count_r - 1'b1;

  assign cmd.push = push;
  assign cmd.pop  = pop;
  assign cmd.ovf  = ovf_r;
  // push writes at the count, pop reads the entry below it
  assign addr     = pop ? pop_idx[AW-1:0] : count_r[AW-1:0];
  assign line     = line_r;

endmodule

/* rtl/bbrf_stack.sv */
// bbrf_stack: line-number stack memory, pop compare stage and result register
// depends on bbrf_pkg
module bbrf_stack #(
  parameter int STACK_DEPTH = 64,
  parameter int LINE_BITS   = 20,
  parameter int AW          = $clog2(STACK_DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bbrf_pkg::stack_cmd_t  cmd,
  input  logic [AW-1:0]         addr,
  input  logic [LINE_BITS-1:0]  line,
  output logic                  s2_free,
  output logic                  out_valid,
  input  logic                  out_stall,
  output bbrf_pkg::out_item_t   out_item
);
  import bbrf_pkg::*;

  logic [LINE_BITS-1:0] mem [STACK_DEPTH];
  logic [LINE_BITS-1:0] rd_r;
  logic [LINE_BITS-1:0] pline_r;
  logic                 povf_r;
  logic                 pop_r, pop_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_r;
  logic                 out_free, emit;
  logic [LINE_BITS+OUT_LINE_W-1:0] open_ext, close_ext;

  // a pop never shares a beat with a push, so no same-entry bypass is needed
  always_ff @(posedge clk) begin
    if (cmd.push) mem[addr] <= line;
    if (cmd.pop) begin
      rd_r    <= mem[addr];
      pline_r <= line;
      povf_r  <= cmd.ovf;
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign s2_free  = !pop_r || out_free;
  assign emit     = pop_r && (pline_r > rd_r);
  assign open_ext  = {{OUT_LINE_W{1'b0}}, rd_r};
  assign close_ext = {{OUT_LINE_W{1'b0}}, pline_r};

  always_comb begin
    pop_nxt       = s2_free ? cmd.pop : pop_r;
    out_valid_nxt = out_free ? emit : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pop_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pop_r       <= pop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && emit) begin
      out_r.open_line  <= open_ext[OUT_LINE_W-1:0];
      out_r.close_line <= close_ext[OUT_LINE_W-1:0];
      out_r.overflowed <= povf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
